// ===== hdl/assert_macros.svh =====
// assertion helpers for the checker files that include them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequent in the same cycle, off during reset
`define ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequent in the next cycle, off during reset
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

// condition implies consequent in the next cycle, also checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, cond, cons) \
   label: assert property (@(posedge clk) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/chp_pkg.sv =====
package chp_pkg;

   localparam int HEADER_BYTES = 21;
   localparam int CRC_COVER    = HEADER_BYTES - 4;
   localparam int COUNT_CAP    = HEADER_BYTES + 1;
   localparam int COUNT_W      = 5;
   localparam int TAIL_POS     = 16;

   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam int RSP_FIELD_W = 139;
   localparam int RSP_DATA_W  = 144;

   typedef enum logic [0:0] {
      CSR_CONTAINER_MAGIC   = 1'b0,
      CSR_SUPPORTED_VERSION = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_WRONG_SIZE   = 3'd1,
      STATUS_BAD_MAGIC    = 3'd2,
      STATUS_BAD_CRC      = 3'd3,
      STATUS_BAD_VERSION  = 3'd4,
      STATUS_READER_OLD   = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0]  tail_size;
      logic [31:0] hdr_len;
      logic [31:0] flag_bits;
      logic [15:0] reader_ver;
      logic [15:0] fmt_ver;
      logic [31:0] magic_word;
      status_type  status;
   } rsp_type;

   // reflected crc-32c, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hdl/checked_header_parser_top.sv =====
// Streaming parser for a 21-byte little-endian header checked by CRC-32C. One header byte
// is taken per cycle with no gaps needed between bytes or headers; the byte marked tlast
// shows its result on rsp once it has passed the input register and then the
// byte-wide CRC update, field capture and checks feeding the result register, which loads
// at the same edge as the header state. The result holds the status and, on success
// only, the decoded fields; on any failure the fields read zero. A byte can still be taken
// while a finished result waits on rsp_tready; only a second last byte stalls behind it.
// csr writes are meant for idle periods.
module checked_header_parser_top (
   input  logic                            clock,
   input  logic                            reset,
   // data_byte[7:0]
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // status[2:0], magic_word[34:3], fmt_ver[50:35], reader_ver[66:51],
   // flag_bits[98:67], hdr_len[130:99], tail_size[138:131], zero pad
   output logic [chp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [0:0]                      csr_index,
   input  logic [31:0]                     csr_wdata
);

   localparam int CW = chp_pkg::COUNT_W;

   logic [31:0] magic_cfg_ff;
   logic [15:0] version_cfg_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        s1_retire, req_fire;

   logic [CW-1:0] count_ff, count_in, count_upd;
   logic [31:0]   crc_ff, crc_in, crc_upd;
   logic [31:0]   magic_ff, magic_in, magic_upd;
   logic [31:0]   version_ff, version_in, version_upd;
   logic [31:0]   flags_ff, flags_in, flags_upd;
   logic [31:0]   length_ff, length_in, length_upd;
   logic [7:0]    tail_ff, tail_in, tail_upd;
   logic [31:0]   stored_ff, stored_in, stored_upd;

   logic             rsp_valid_ff, rsp_valid_in;
   chp_pkg::rsp_type rsp_ff, rsp_in;
   chp_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_cfg_ff   <= '0;
         version_cfg_ff <= 16'd1;
      end else if (csr_wr_en) begin
         unique case (chp_pkg::csr_index_type'(csr_index))
            chp_pkg::CSR_CONTAINER_MAGIC:   magic_cfg_ff   <= csr_wdata;
            chp_pkg::CSR_SUPPORTED_VERSION: version_cfg_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // a non-last item always retires; a last one needs room in the result register
   assign s1_retire  = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_retire;
   assign req_fire   = req_tvalid && req_tready;
   assign s1_valid_in = req_fire ? 1'b1 : (s1_retire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // header state after taking this byte
   always_comb begin
      crc_upd     = crc_ff;
      magic_upd   = magic_ff;
      version_upd = version_ff;
      flags_upd   = flags_ff;
      length_upd  = length_ff;
      tail_upd    = tail_ff;
      stored_upd  = stored_ff;
      if (count_ff < CW'(chp_pkg::HEADER_BYTES)) begin
         if (count_ff < CW'(chp_pkg::CRC_COVER)) begin
            crc_upd = chp_pkg::crc_byte(crc_ff, s1_byte_ff);
         end
         priority if (count_ff < CW'(4)) begin
            magic_upd = {s1_byte_ff, magic_ff[31:8]};
         end else if (count_ff < CW'(8)) begin
            version_upd = {s1_byte_ff, version_ff[31:8]};
         end else if (count_ff < CW'(12)) begin
            flags_upd = {s1_byte_ff, flags_ff[31:8]};
         end else if (count_ff < CW'(chp_pkg::TAIL_POS)) begin
            length_upd = {s1_byte_ff, length_ff[31:8]};
         end else if (count_ff == CW'(chp_pkg::TAIL_POS)) begin
            tail_upd = s1_byte_ff;
         end else begin
            stored_upd = {s1_byte_ff, stored_ff[31:8]};
         end
      end
      // saturate one past the header size so oversize input is seen
      count_upd = (count_ff < CW'(chp_pkg::COUNT_CAP)) ? count_ff + CW'(1) : count_ff;
   end

   always_comb begin
      priority if (count_upd != CW'(chp_pkg::HEADER_BYTES)) begin
         status = chp_pkg::STATUS_WRONG_SIZE;
      end else if (magic_upd != magic_cfg_ff) begin
         status = chp_pkg::STATUS_BAD_MAGIC;
      end else if (~crc_upd != stored_upd) begin
         status = chp_pkg::STATUS_BAD_CRC;
      end else if (version_upd[15:0] != version_cfg_ff) begin
         status = chp_pkg::STATUS_BAD_VERSION;
      end else if (version_upd[31:16] > version_cfg_ff) begin
         status = chp_pkg::STATUS_READER_OLD;
      end else begin
         status = chp_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = status;
      if (status == chp_pkg::STATUS_OK) begin
         rsp_in.magic_word = magic_upd;
         rsp_in.fmt_ver    = version_upd[15:0];
         rsp_in.reader_ver = version_upd[31:16];
         rsp_in.flag_bits  = flags_upd;
         rsp_in.hdr_len    = length_upd;
         rsp_in.tail_size  = tail_upd;
      end
   end

   // the last byte leaves the state cleared for the next header
   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      magic_in   = magic_ff;
      version_in = version_ff;
      flags_in   = flags_ff;
      length_in  = length_ff;
      tail_in    = tail_ff;
      stored_in  = stored_ff;
      if (s1_retire) begin
         if (s1_last_ff) begin
            count_in   = '0;
            crc_in     = chp_pkg::CRC_INIT;
            magic_in   = '0;
            version_in = '0;
            flags_in   = '0;
            length_in  = '0;
            tail_in    = '0;
            stored_in  = '0;
         end else begin
            count_in   = count_upd;
            crc_in     = crc_upd;
            magic_in   = magic_upd;
            version_in = version_upd;
            flags_in   = flags_upd;
            length_in  = length_upd;
            tail_in    = tail_upd;
            stored_in  = stored_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_ff     <= chp_pkg::CRC_INIT;
         magic_ff   <= '0;
         version_ff <= '0;
         flags_ff   <= '0;
         length_ff  <= '0;
         tail_ff    <= '0;
         stored_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         magic_ff   <= magic_in;
         version_ff <= version_in;
         flags_ff   <= flags_in;
         length_ff  <= length_in;
         tail_ff    <= tail_in;
         stored_ff  <= stored_in;
      end
   end

   assign rsp_valid_in = (s1_retire && s1_last_ff) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_retire && s1_last_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(chp_pkg::RSP_DATA_W - chp_pkg::RSP_FIELD_W)'(0), rsp_ff};

endmodule

// ===== hdl/chp_checker.sv =====
`include "assert_macros.svh"

module chp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [chp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   logic status_ok;
   logic status_known;
   logic fields_zero;
   logic rsp_stall;

   assign status_ok    = rsp_tdata[2:0] == chp_pkg::STATUS_OK;
   assign status_known = rsp_tdata[2:0] <= chp_pkg::STATUS_READER_OLD;
   assign fields_zero  = rsp_tdata[chp_pkg::RSP_DATA_W-1:3] == '0;
   assign rsp_stall    = rsp_tvalid && !rsp_tready;

   `ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_tvalid)
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLY(a_status_known, clock, reset, rsp_tvalid, status_known)
   `ASSERT_IMPLY(a_failed_fields_zero, clock, reset, rsp_tvalid && !status_ok, fields_zero)
   `ASSERT_IMPLY(a_req_ready_when_rsp_free, clock, reset, !rsp_tvalid && req_tvalid, req_tready)

endmodule

bind checked_header_parser_top chp_checker u_chp_checker (.*);

// ===== tb/checked_header_checker.sv =====
`timescale 1ns / 1ps

package hdr_crc_pkg;

   localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F6_3B78;

   // reflected crc-32c, one byte, lsb first
   function automatic logic [31:0] crc32c_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] acc;
      acc = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CASTAGNOLI_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

module checked_header_checker
   import chp_pkg::*;
   import hdr_crc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tlast,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_wr_en,
   input  logic [0:0]              csr_index,
   input  logic [31:0]             csr_wdata,
   output int                      fail_count,
   output int                      verdicts_waiting
);

   logic [31:0]        magic_cfg;
   logic [15:0]        version_cfg;

   logic [COUNT_W-1:0] byte_pos;
   logic [31:0]        crc_acc;
   logic [31:0]        magic_acc;
   logic [31:0]        version_acc;
   logic [31:0]        flags_acc;
   logic [31:0]        length_acc;
   logic [31:0]        stored_crc_acc;
   logic [7:0]         tail_acc;

   rsp_type            pending_verdicts[$];
   int                 errors = 0;

   task clear_header();
      byte_pos       = '0;
      crc_acc        = '1;
      magic_acc      = '0;
      version_acc    = '0;
      flags_acc      = '0;
      length_acc     = '0;
      stored_crc_acc = '0;
      tail_acc       = '0;
   endtask

   // predicts the verdict for the header slice that ends with a last byte
   task take_header_byte(input logic [7:0] b, input logic is_last);
      rsp_type verdict;
      if (byte_pos < HEADER_BYTES) begin
         if (byte_pos < CRC_COVER) begin
            crc_acc = crc32c_update(crc_acc, b);
         end
         if (byte_pos < 4) begin
            magic_acc = {b, magic_acc[31:8]};
         end else if (byte_pos < 8) begin
            version_acc = {b, version_acc[31:8]};
         end else if (byte_pos < 12) begin
            flags_acc = {b, flags_acc[31:8]};
         end else if (byte_pos < 16) begin
            length_acc = {b, length_acc[31:8]};
         end else if (byte_pos == TAIL_POS) begin
            tail_acc = b;
         end else begin
            stored_crc_acc = {b, stored_crc_acc[31:8]};
         end
      end
      // count saturates so that oversize slices still read as wrong size
      if (byte_pos < COUNT_CAP) begin
         byte_pos = byte_pos + 1'b1;
      end
      if (is_last) begin
         verdict = '0;
         if (byte_pos != HEADER_BYTES) begin
            verdict.status = STATUS_WRONG_SIZE;
         end else if (magic_acc != magic_cfg) begin
            verdict.status = STATUS_BAD_MAGIC;
         end else if (~crc_acc != stored_crc_acc) begin
            verdict.status = STATUS_BAD_CRC;
         end else if (version_acc[15:0] != version_cfg) begin
            verdict.status = STATUS_BAD_VERSION;
         end else if (version_acc[31:16] > version_cfg) begin
            verdict.status = STATUS_READER_OLD;
         end else begin
            verdict.status     = STATUS_OK;
            verdict.magic_word = magic_acc;
            verdict.fmt_ver    = version_acc[15:0];
            verdict.reader_ver = version_acc[31:16];
            verdict.flag_bits  = flags_acc;
            verdict.hdr_len    = length_acc;
            verdict.tail_size  = tail_acc;
         end
         pending_verdicts.push_back(verdict);
         clear_header();
      end
   endtask

   task check_verdict(input rsp_type got);
      rsp_type want;
      if (pending_verdicts.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("unexpected verdict at %0t: status %0d magic %h", $realtime, got.status,
                     got.magic_word);
         end
      end else begin
         want = pending_verdicts.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("verdict mismatch at %0t", $realtime);
               $display("  expected status %0d magic %h fmt %h minv %h flags %h len %h tail %h",
                        want.status, want.magic_word, want.fmt_ver,
                        want.reader_ver, want.flag_bits, want.hdr_len,
                        want.tail_size);
               $display("  actual   status %0d magic %h fmt %h minv %h flags %h len %h tail %h",
                        got.status, got.magic_word, got.fmt_ver,
                        got.reader_ver, got.flag_bits, got.hdr_len,
                        got.tail_size);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         magic_cfg   = '0;
         version_cfg = 16'd1;
         clear_header();
         pending_verdicts.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CONTAINER_MAGIC: begin
                  magic_cfg = csr_wdata;
               end
               CSR_SUPPORTED_VERSION: begin
                  version_cfg = csr_wdata[15:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            check_verdict(rsp_tdata[RSP_FIELD_W-1:0]);
         end
         if (req_tvalid && req_tready) begin
            take_header_byte(req_tdata, req_tlast);
         end
      end
      fail_count       <= errors;
      verdicts_waiting <= pending_verdicts.size();
   end

endmodule

// ===== tb/tb_checked_header_parser_top.sv =====
`timescale 1ns / 1ps

module tb_checked_header_parser_top;
   import chp_pkg::*;
   import hdr_crc_pkg::*;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 320;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [7:0]            req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [0:0]            csr_index = '0;
   logic [31:0]           csr_wdata = '0;

   int                    fail_count;
   int                    verdicts_waiting;
   int                    cycle_count = 0;
   int                    idle_pct = 0;
   int                    stall_pct = 0;

   // values the generator uses to build headers that pass
   logic [31:0]           gen_magic = '0;
   logic [15:0]           gen_version = 16'd1;
   logic [7:0]            slice_q[$];

   checked_header_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   checked_header_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .verdicts_waiting (verdicts_waiting)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_CONTAINER_MAGIC) begin
         gen_magic = val;
      end else begin
         gen_version = val[15:0];
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_slice();
      for (int i = 0; i < slice_q.size(); i++) begin
         send_byte(slice_q[i], i == slice_q.size() - 1);
      end
   endtask

   // appends the 17 covered bytes and the stored crc, optionally spoiled
   task automatic frame_header(input logic [135:0] body, input logic crc_bad);
      logic [31:0] crc;
      crc = '1;
      for (int i = 0; i < CRC_COVER; i++) begin
         slice_q.push_back(body[8*i +: 8]);
         crc = crc32c_update(crc, body[8*i +: 8]);
      end
      crc = ~crc;
      if (crc_bad) begin
         crc ^= 32'h1 << $urandom_range(31);
      end
      for (int i = 0; i < 4; i++) begin
         slice_q.push_back(crc[8*i +: 8]);
      end
   endtask

   // well-formed headers with random content, some spoiled in one way or with random
   // magic and versions, some cut short or overlong, and some plain noise
   task automatic build_slice();
      logic [31:0] magic;
      logic [31:0] flags;
      logic [31:0] hlen;
      logic [15:0] fmt;
      logic [15:0] minv;
      logic [7:0]  tail;
      int          pick;
      int          keep;
      slice_q.delete();
      pick = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 40)) slice_q.push_back(8'($urandom_range(255)));
      end else begin
         magic = gen_magic;
         fmt   = gen_version;
         minv  = 16'($urandom_range(0, gen_version));
         flags = $urandom();
         hlen  = $urandom();
         tail  = 8'($urandom_range(255));
         if (pick >= 20 && pick < 28) begin
            magic ^= 32'h1 << $urandom_range(31);
         end else if (pick >= 28 && pick < 36) begin
            fmt ^= 16'h1 << $urandom_range(15);
         end else if (pick >= 36 && pick < 44 && gen_version != 16'hFFFF) begin
            minv = 16'($urandom_range(int'(gen_version) + 1, 65535));
         end else if (pick >= 44 && pick < 52) begin
            magic = $urandom();
            fmt   = 16'($urandom_range(65535));
            minv  = 16'($urandom_range(65535));
         end
         frame_header({tail, hlen, flags, minv, fmt, magic}, pick >= 8 && pick < 20);
         if (pick >= 86 && pick < 93) begin
            keep = $urandom_range(1, HEADER_BYTES - 1);
            while (slice_q.size() > keep) void'(slice_q.pop_back());
         end else if (pick >= 93) begin
            repeat ($urandom_range(1, 12)) slice_q.push_back(8'($urandom_range(255)));
         end
      end
   endtask

   // last item is in; wait for every verdict and for the pipe to drain
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(CSR_CONTAINER_MAGIC, 32'hFFFF_FFFF);
      write_reg(CSR_SUPPORTED_VERSION, 32'h0000_FFFF);
      // one-byte slice, then a good header with every field at all ones
      send_byte(8'h00, 1'b1);
      slice_q.delete();
      frame_header({136{1'b1}}, 1'b0);
      send_slice();
      quiesce();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               write_reg(CSR_CONTAINER_MAGIC, 32'h0000_0000);
               write_reg(CSR_SUPPORTED_VERSION, 32'h0000_0000);
            end
            1: begin
               idle_pct  = 77;
               stall_pct = 0;
               write_reg(CSR_CONTAINER_MAGIC, $urandom());
               write_reg(CSR_SUPPORTED_VERSION, 32'h0000_0001);
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 77;
               write_reg(CSR_CONTAINER_MAGIC, $urandom());
               write_reg(CSR_SUPPORTED_VERSION, 32'h0000_FFFF);
            end
            default: begin
               idle_pct  = 36;
               stall_pct = 36;
               write_reg(CSR_CONTAINER_MAGIC, $urandom());
               write_reg(CSR_SUPPORTED_VERSION, $urandom_range(65535));
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_slice();
            sent += slice_q.size();
            send_slice();
         end
         quiesce();
      end

      if (fail_count == 0 && verdicts_waiting == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
